>>> sv/rsie_pkg.sv
// ----------------------------------------------------------------------------
// rsie_pkg
// Shared types and constants for the register/stack instruction executor:
// field widths, command and status codes, and the decoded slot format that
// passes from the front end through the queue to the execute stage.
// ----------------------------------------------------------------------------
package rsie_pkg;

   // field widths
   localparam int CMD_W     = 3;
   localparam int REG_SEL_W = 3;
   localparam int WORD_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int FILL_W    = 9;
   localparam int PC_W      = 16;

   // default sizes handed to the top level
   localparam int DEF_REGISTER_COUNT = 8;
   localparam int DEF_STACK_DEPTH    = 256;

   // decoupling queue between front end and execute stage
   localparam int QUEUE_DEPTH = 2;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 3'd0,
      CMD_ADD     = 3'd1,
      CMD_SUB     = 3'd2,
      CMD_MUL     = 3'd3,
      CMD_PUSH    = 3'd4,
      CMD_POP     = 3'd5,
      CMD_HALT    = 3'd6,
      CMD_UNKNOWN = 3'd7
   } command_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_OVERFLOW  = 3'd1,
      STAT_UNDERFLOW = 3'd2,
      STAT_HALTED    = 3'd3,
      STAT_UNKNOWN   = 3'd4
   } status_type;

   // classified instruction as held in the queue
   typedef struct packed {
      command_type                 command;
      logic                        writes_reg;
      logic                        is_push;
      logic                        is_pop;
      status_type                  fixed_status;
      logic [REG_SEL_W-1:0]        dest_reg;
      logic [REG_SEL_W-1:0]        src_a_reg;
      logic [REG_SEL_W-1:0]        src_b_reg;
      logic signed [WORD_W-1:0]    immediate;
   } slot_type;

endpackage

>>> sv/rsie_req_if.sv
// ----------------------------------------------------------------------------
// rsie_req_if
// Instruction channel: valid/ready handshake with the decoded instruction
// fields as payload.
// ----------------------------------------------------------------------------
interface rsie_req_if import rsie_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic [REG_SEL_W-1:0]       dest_reg;
   logic [REG_SEL_W-1:0]       src_a_reg;
   logic [REG_SEL_W-1:0]       src_b_reg;
   logic signed [WORD_W-1:0]   immediate;

   modport source (
      output valid, command, dest_reg, src_a_reg, src_b_reg, immediate,
      input  ready
   );

   modport sink (
      input  valid, command, dest_reg, src_a_reg, src_b_reg, immediate,
      output ready
   );

endinterface

>>> sv/rsie_rsp_if.sv
// ----------------------------------------------------------------------------
// rsie_rsp_if
// Result channel: valid/ready handshake carrying status, written value,
// stack fill and program counter.
// ----------------------------------------------------------------------------
interface rsie_rsp_if import rsie_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [WORD_W-1:0]   written_value;
   logic [FILL_W-1:0]          stack_fill;
   logic [PC_W-1:0]            program_counter;

   modport source (
      output valid, status, written_value, stack_fill, program_counter,
      input  ready
   );

   modport sink (
      input  valid, status, written_value, stack_fill, program_counter,
      output ready
   );

endinterface

>>> sv/rsie_ram.sv
// ----------------------------------------------------------------------------
// rsie_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read data output that holds until the next read.
// ----------------------------------------------------------------------------
module rsie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/rsie_front.sv
// ----------------------------------------------------------------------------
// rsie_front
// Front end: takes instruction beats and classifies them into queue slots
// (register writer, push, pop, or fixed-status report).
// ----------------------------------------------------------------------------
module rsie_front import rsie_pkg::*; (
   rsie_req_if.sink   req_bus,
   input  logic       q_ready,
   output logic       q_push,
   output slot_type   q_slot
);

   // beat passes straight into the queue when it has room
   assign req_bus.ready = q_ready;
   assign q_push        = req_bus.valid;

   // classify the instruction
   always_comb begin
      q_slot              = '0;
      q_slot.command      = command_type'(req_bus.command);
      q_slot.dest_reg     = req_bus.dest_reg;
      q_slot.src_a_reg    = req_bus.src_a_reg;
      q_slot.src_b_reg    = req_bus.src_b_reg;
      q_slot.immediate    = req_bus.immediate;
      q_slot.fixed_status = STAT_OK;
      case (command_type'(req_bus.command))
         CMD_LOAD, CMD_ADD, CMD_SUB, CMD_MUL: begin
            q_slot.writes_reg = 1'b1;
         end
         CMD_PUSH: begin
            q_slot.is_push = 1'b1;
         end
         CMD_POP: begin
            q_slot.is_pop = 1'b1;
         end
         CMD_HALT: begin
            q_slot.fixed_status = STAT_HALTED;
         end
         default: begin
            q_slot.fixed_status = STAT_UNKNOWN;
         end
      endcase
   end

endmodule

>>> sv/rsie_queue.sv
// ----------------------------------------------------------------------------
// rsie_queue
// Short slot queue between the front end and the execute stage so that
// either side can stall on its own.
// ----------------------------------------------------------------------------
module rsie_queue import rsie_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  slot_type   in_slot,
   output logic       out_valid,
   input  logic       out_take,
   output slot_type   out_slot
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   slot_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_write;
   logic              do_read;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_slot  = entries_ff[rd_ptr_ff];
   assign do_write  = in_valid && in_ready;
   assign do_read   = out_take && out_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_write) begin
         entries_ff[wr_ptr_ff] <= in_slot;
      end
   end

endmodule

>>> sv/rsie_back.sv
// ----------------------------------------------------------------------------
// rsie_back
// Execute stage: register file, arithmetic, stack memory with fill count,
// program counter, and the result output register. A popped word comes
// from the stack memory in the cycle after the pop and is forwarded to the
// next instruction while it is written into the register file.
// ----------------------------------------------------------------------------
module rsie_back import rsie_pkg::*; #(
   parameter int REGISTER_COUNT = DEF_REGISTER_COUNT,
   parameter int STACK_DEPTH    = DEF_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        slot_valid,
   input  slot_type    slot,
   output logic        slot_take,
   rsie_rsp_if.source  rsp_bus
);

   localparam int REG_IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam int SEL_EXT_W = ((REG_IDX_W > REG_SEL_W) ? REG_IDX_W : REG_SEL_W) + 1;
   localparam int ADDR_W    = $clog2(STACK_DEPTH);
   localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);

   // architectural state
   logic [WORD_W-1:0]      regs_ff [REGISTER_COUNT];
   logic [WORD_W-1:0]      regs_in [REGISTER_COUNT];
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [PC_W-1:0]        pc_ff, pc_in;

   // output register and pending pop write-back
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, out_status_in;
   logic [WORD_W-1:0]      out_value_ff, out_value_in;
   logic [FILL_W-1:0]      out_fill_ff, out_fill_in;
   logic [PC_W-1:0]        out_pc_ff, out_pc_in;
   logic                   out_pop_ff, out_pop_in;
   logic                   pop_wb_ff, pop_wb_in;
   logic [REG_SEL_W-1:0]   pop_dest_ff, pop_dest_in;

   // execute signals
   logic                   advance;
   logic [WORD_W-1:0]      val_a, val_b, val_d;
   logic [WORD_W-1:0]      product;
   logic [WORD_W-1:0]      alu_value;
   logic                   stack_full, stack_empty;
   logic                   push_ok, pop_ok;
   logic                   reg_wr;
   logic [COUNT_W-1:0]     push_pos, pop_pos;
   logic [WORD_W-1:0]      ram_rd_data;

   function automatic logic sel_valid(input logic [REG_SEL_W-1:0] sel);
      return SEL_EXT_W'(sel) < SEL_EXT_W'(REGISTER_COUNT);
   endfunction

   function automatic logic [REG_IDX_W-1:0] sel_index(input logic [REG_SEL_W-1:0] sel);
      logic [SEL_EXT_W-1:0] ext;
      ext = SEL_EXT_W'(sel);
      return ext[REG_IDX_W-1:0];
   endfunction

   // register read with forwarding of a pending popped word
   function automatic logic [WORD_W-1:0] read_reg(input logic [REG_SEL_W-1:0] sel);
      logic [WORD_W-1:0] word;
      word = '0;
      if (sel_valid(sel)) begin
         if (pop_wb_ff && (pop_dest_ff == sel)) begin
            word = ram_rd_data;
         end else begin
            word = regs_ff[sel_index(sel)];
         end
      end
      return word;
   endfunction

   // the stage moves when a slot waits and the output register frees up
   assign advance   = slot_valid && (!out_valid_ff || rsp_bus.ready);
   assign slot_take = advance;

   // operand fetch and arithmetic
   always_comb begin
      val_a = read_reg(slot.src_a_reg);
      val_b = read_reg(slot.src_b_reg);
      val_d = read_reg(slot.dest_reg);
   end

   assign product = val_a * val_b;

   always_comb begin
      case (slot.command)
         CMD_LOAD: alu_value = slot.immediate;
         CMD_ADD:  alu_value = val_a + val_b;
         CMD_SUB:  alu_value = val_a - val_b;
         CMD_MUL:  alu_value = product;
         default:  alu_value = '0;
      endcase
   end

   // stack checks and descending addresses
   assign stack_full  = (count_ff == COUNT_W'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign push_ok     = slot.is_push && !stack_full;
   assign pop_ok      = slot.is_pop && !stack_empty;
   assign push_pos    = COUNT_W'(STACK_DEPTH - 1) - count_ff;
   assign pop_pos     = COUNT_W'(STACK_DEPTH) - count_ff;
   assign reg_wr      = advance && slot.writes_reg && sel_valid(slot.dest_reg);

   // next state of the execute stage
   always_comb begin
      count_in      = count_ff;
      pc_in         = pc_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_fill_in   = out_fill_ff;
      out_pc_in     = out_pc_ff;
      out_pop_in    = out_pop_ff;
      pop_wb_in     = 1'b0;
      pop_dest_in   = pop_dest_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in  = 1'b1;
         out_status_in = slot.fixed_status;
         out_value_in  = '0;
         out_pop_in    = 1'b0;
         if (slot.writes_reg) begin
            out_value_in = alu_value;
         end else if (slot.is_push) begin
            if (stack_full) begin
               out_status_in = STAT_OVERFLOW;
            end else begin
               out_value_in = val_d;
               count_in     = count_ff + 1'b1;
            end
         end else if (slot.is_pop) begin
            if (stack_empty) begin
               out_status_in = STAT_UNDERFLOW;
            end else begin
               out_pop_in  = 1'b1;
               pop_wb_in   = 1'b1;
               pop_dest_in = slot.dest_reg;
               count_in    = count_ff - 1'b1;
            end
         end
         pc_in       = pc_ff + 1'b1;
         out_pc_in   = pc_ff + 1'b1;
         out_fill_in = FILL_W'(count_in);
      end
   end

   // register file: the newer execute write wins over the popped word
   always_comb begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
         regs_in[i] = regs_ff[i];
         if (reg_wr && (sel_index(slot.dest_reg) == REG_IDX_W'(i))) begin
            regs_in[i] = alu_value;
         end else if (pop_wb_ff && sel_valid(pop_dest_ff) &&
                      (sel_index(pop_dest_ff) == REG_IDX_W'(i))) begin
            regs_in[i] = ram_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
         count_ff     <= '0;
         pc_ff        <= '0;
         out_valid_ff <= 1'b0;
         out_pop_ff   <= 1'b0;
         pop_wb_ff    <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         count_ff     <= count_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
         out_pop_ff   <= out_pop_in;
         pop_wb_ff    <= pop_wb_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_fill_ff   <= out_fill_in;
      out_pc_ff     <= out_pc_in;
      pop_dest_ff   <= pop_dest_in;
   end

   // stack memory
   rsie_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (advance && push_ok),
      .wr_addr (push_pos[ADDR_W-1:0]),
      .wr_data (val_d),
      .rd_en   (advance && pop_ok),
      .rd_addr (pop_pos[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // result beat; a popped word is read straight from the memory output
   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = out_status_ff;
   assign rsp_bus.written_value   = out_pop_ff ? ram_rd_data : out_value_ff;
   assign rsp_bus.stack_fill      = out_fill_ff;
   assign rsp_bus.program_counter = out_pc_ff;

endmodule

>>> sv/register_stack_instruction_executor.sv
// ----------------------------------------------------------------------------
// register_stack_instruction_executor
// Executes decoded load/arithmetic/push/pop/halt instructions against a
// register file, a descending word stack and an instruction counter.
//
//   channel   dir   handshake       payload
//   req_bus   in    valid / ready   command, dest_reg, src_a_reg, src_b_reg,
//                                   immediate
//   rsp_bus   out   valid / ready   status, written_value, stack_fill,
//                                   program_counter
//
// One instruction per cycle sustained while rsp_bus is ready; the single
// execute stage sets the rate, with one multiplier and one stack memory
// (write port for push, read for pop). Each req beat passes through the
// queue and the output register on the way to its rsp beat. A popped word
// arrives from the stack memory's registered read and is forwarded to the
// following instruction, so pops cause no bubble. Synchronous reset clears
// registers, fill count and counter; the stack memory is not cleared.
// A stalled rsp beat holds the output register; the two-slot queue then
// fills and req_bus.ready drops.
// ----------------------------------------------------------------------------
module register_stack_instruction_executor import rsie_pkg::*; #(
   parameter int REGISTER_COUNT = DEF_REGISTER_COUNT,
   parameter int STACK_DEPTH    = DEF_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   rsie_req_if.sink    req_bus,
   rsie_rsp_if.source  rsp_bus
);

   logic       q_ready;
   logic       q_push;
   slot_type   q_in_slot;
   logic       q_valid;
   logic       q_take;
   slot_type   q_out_slot;

   // classify incoming beats
   rsie_front u_front (
      .req_bus (req_bus),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_slot  (q_in_slot)
   );

   // decoupling queue
   rsie_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_push),
      .in_ready  (q_ready),
      .in_slot   (q_in_slot),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_slot  (q_out_slot)
   );

   // execute and respond
   rsie_back #(
      .REGISTER_COUNT (REGISTER_COUNT),
      .STACK_DEPTH    (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .slot_valid (q_valid),
      .slot       (q_out_slot),
      .slot_take  (q_take),
      .rsp_bus    (rsp_bus)
   );

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result beat presented right after reset");

   // execute stage takes only a present slot
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("execute stage took a slot from an empty queue");

   // a slot not taken stays queued
   a_slot_held: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_take |=> q_valid)
      else $error("queued slot lost without being taken");

   // any non-ok status carries a zero value
   a_status_value: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status != STAT_OK) |-> (rsp_bus.written_value == '0))
      else $error("non-ok result with nonzero written value");

endmodule

>>> dv/rsie_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsie_checker
// Watches the instruction and result channels of the executor. For every
// accepted instruction beat it runs its own model of the registers, stack and
// counter, queues the outcome, and compares each accepted result beat with
// the oldest queued outcome. Hands a failure count and the number of
// outstanding outcomes to the testbench top.
// ----------------------------------------------------------------------------
module rsie_checker import rsie_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   rsie_req_if    req_mon,
   rsie_rsp_if    rsp_mon,
   output int     fail_count,
   output int     pending_count
);

   typedef struct packed {
      status_type           status;
      logic [WORD_W-1:0]    written_value;
      logic [FILL_W-1:0]    stack_fill;
      logic [PC_W-1:0]      program_counter;
   } outcome_type;

   // shadow machine state
   logic [WORD_W-1:0]   reg_shadow [DEF_REGISTER_COUNT];
   logic [WORD_W-1:0]   stack_shadow [DEF_STACK_DEPTH];
   logic [FILL_W-1:0]   fill_shadow;
   logic [PC_W-1:0]     pc_shadow;
   outcome_type         outcome_q [$];

   // register reads outside the file give zero
   function automatic logic [WORD_W-1:0] read_reg(input logic [REG_SEL_W-1:0] idx);
      if (int'(idx) < DEF_REGISTER_COUNT) return reg_shadow[idx];
      return '0;
   endfunction

   // register writes outside the file are dropped
   function automatic void write_reg(input logic [REG_SEL_W-1:0] idx,
                                     input logic [WORD_W-1:0] val);
      if (int'(idx) < DEF_REGISTER_COUNT) reg_shadow[idx] = val;
   endfunction

   // execute one instruction on the shadow state
   function automatic outcome_type predict_step(
      input command_type            cmd,
      input logic [REG_SEL_W-1:0]   dest,
      input logic [REG_SEL_W-1:0]   src_a,
      input logic [REG_SEL_W-1:0]   src_b,
      input logic [WORD_W-1:0]      imm
   );
      outcome_type result;
      result.status = STAT_OK;
      result.written_value = '0;
      case (cmd)
         CMD_LOAD: begin
            result.written_value = imm;
            write_reg(dest, imm);
         end
         CMD_ADD: begin
            result.written_value = read_reg(src_a) + read_reg(src_b);
            write_reg(dest, result.written_value);
         end
         CMD_SUB: begin
            result.written_value = read_reg(src_a) - read_reg(src_b);
            write_reg(dest, result.written_value);
         end
         CMD_MUL: begin
            result.written_value = read_reg(src_a) * read_reg(src_b);
            write_reg(dest, result.written_value);
         end
         CMD_PUSH: begin
            // descending stack, full stack leaves registers and stack as is
            if (int'(fill_shadow) >= DEF_STACK_DEPTH) begin
               result.status = STAT_OVERFLOW;
            end else begin
               result.written_value = read_reg(dest);
               stack_shadow[DEF_STACK_DEPTH - 1 - int'(fill_shadow)] = result.written_value;
               fill_shadow = fill_shadow + 1'b1;
            end
         end
         CMD_POP: begin
            if (fill_shadow == '0) begin
               result.status = STAT_UNDERFLOW;
            end else begin
               fill_shadow = fill_shadow - 1'b1;
               result.written_value = stack_shadow[DEF_STACK_DEPTH - 1 - int'(fill_shadow)];
               write_reg(dest, result.written_value);
            end
         end
         CMD_HALT: begin
            result.status = STAT_HALTED;
         end
         default: begin
            result.status = STAT_UNKNOWN;
         end
      endcase
      // counter advances on every instruction
      pc_shadow = pc_shadow + 1'b1;
      result.stack_fill = fill_shadow;
      result.program_counter = pc_shadow;
      return result;
   endfunction

   // compare result beats, then record the outcome of the instruction beat
   always @(posedge clock) begin : scoreboard
      outcome_type want;
      int          errors;
      errors = 0;
      if (reset) begin
         for (int i = 0; i < DEF_REGISTER_COUNT; i++) reg_shadow[i] = '0;
         fill_shadow = '0;
         pc_shadow = '0;
         outcome_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: result beat with nothing expected: status %0d value %h fill %0d pc %0d",
                        $time, rsp_mon.status, rsp_mon.written_value, rsp_mon.stack_fill,
                        rsp_mon.program_counter);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_mon.status);
                  errors++;
               end
               if (rsp_mon.written_value !== want.written_value) begin
                  $display("%0t: written_value mismatch: expected %h actual %h",
                           $time, want.written_value, rsp_mon.written_value);
                  errors++;
               end
               if (rsp_mon.stack_fill !== want.stack_fill) begin
                  $display("%0t: stack_fill mismatch: expected %0d actual %0d",
                           $time, want.stack_fill, rsp_mon.stack_fill);
                  errors++;
               end
               if (rsp_mon.program_counter !== want.program_counter) begin
                  $display("%0t: program_counter mismatch: expected %0d actual %0d",
                           $time, want.program_counter, rsp_mon.program_counter);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            outcome_q.push_back(predict_step(command_type'(req_mon.command),
                                             req_mon.dest_reg, req_mon.src_a_reg,
                                             req_mon.src_b_reg, req_mon.immediate));
         end
         fail_count <= fail_count + errors;
      end
      pending_count <= outcome_q.size();
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Instruction stream stimulus for the register/stack instruction executor:
// a directed opening over field extremes, every command and the stack edge
// cases, then random segments of arithmetic, push/pop bursts, full fills and
// drains, and noise, under changing sender idle and receiver stall phases.
// Checking is done by rsie_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import rsie_pkg::*;

   localparam int ITEM_TARGET  = 1325;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 331;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   fail_count;
   int   pending_count;
   int   item_count;
   int   stack_level;
   int   fills_done;
   int   quiet_cycles;

   rsie_req_if req_bus ();
   rsie_rsp_if rsp_bus ();

   register_stack_instruction_executor DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rsie_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [REG_SEL_W-1:0] rand_reg();
      return REG_SEL_W'($urandom_range(0, 7));
   endfunction

   // immediates lean on the extremes and on small values
   function automatic logic [WORD_W-1:0] pick_immediate();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // drive one instruction beat and wait for it to be taken
   task automatic send_instruction(
      input command_type            cmd,
      input logic [REG_SEL_W-1:0]   dest,
      input logic [REG_SEL_W-1:0]   src_a,
      input logic [REG_SEL_W-1:0]   src_b,
      input logic [WORD_W-1:0]      imm
   );
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.dest_reg  <= dest;
      req_bus.src_a_reg <= src_a;
      req_bus.src_b_reg <= src_b;
      req_bus.immediate <= imm;
      do @(posedge clock); while (!req_bus.ready);
      item_count++;
      if (cmd == CMD_PUSH && stack_level < DEF_STACK_DEPTH) stack_level++;
      if (cmd == CMD_POP && stack_level > 0) stack_level--;
   endtask

   // push until full, then a few overflowing pushes
   task automatic fill_stack();
      while (stack_level < DEF_STACK_DEPTH)
         send_instruction(CMD_PUSH, rand_reg(), rand_reg(), rand_reg(), $urandom());
      repeat ($urandom_range(1, 3))
         send_instruction(CMD_PUSH, rand_reg(), rand_reg(), rand_reg(), $urandom());
      fills_done++;
   endtask

   // stimulus
   initial begin
      int seg;
      int n;
      reset = 1'b1;
      idle_pct = 0;
      stall_pct = 0;
      item_count = 0;
      stack_level = 0;
      fills_done = 0;
      quiet_cycles = 0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_LOAD;
      req_bus.dest_reg = '0;
      req_bus.src_a_reg = '0;
      req_bus.src_b_reg = '0;
      req_bus.immediate = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty pop, extremes, wraparound, stack order, halt, unknown
      send_instruction(CMD_POP,  3'd0, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_instruction(CMD_LOAD, 3'd0, 3'd7, 3'd0, 32'h7FFF_FFFF);
      send_instruction(CMD_LOAD, 3'd7, 3'd0, 3'd7, 32'h8000_0000);
      send_instruction(CMD_LOAD, 3'd1, 3'd3, 3'd4, 32'hFFFF_FFFF);
      send_instruction(CMD_LOAD, 3'd2, 3'd5, 3'd6, 32'h0000_0000);
      send_instruction(CMD_ADD,  3'd3, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_ADD,  3'd4, 3'd0, 3'd7, 32'h0);
      send_instruction(CMD_SUB,  3'd5, 3'd2, 3'd7, 32'h0);
      send_instruction(CMD_SUB,  3'd6, 3'd7, 3'd0, 32'h0);
      send_instruction(CMD_MUL,  3'd3, 3'd1, 3'd7, 32'h0);
      send_instruction(CMD_MUL,  3'd4, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_MUL,  3'd5, 3'd1, 3'd1, 32'h0);
      send_instruction(CMD_PUSH, 3'd7, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_PUSH, 3'd0, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_PUSH, 3'd1, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_POP,  3'd2, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_POP,  3'd3, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_POP,  3'd4, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_POP,  3'd5, 3'd0, 3'd0, 32'h0);
      send_instruction(CMD_HALT, rand_reg(), rand_reg(), rand_reg(), $urandom());
      send_instruction(CMD_LOAD, 3'd6, 3'd0, 3'd0, 32'h5A5A_A5A5);
      send_instruction(CMD_UNKNOWN, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_instruction(CMD_UNKNOWN, 3'd0, 3'd0, 3'd0, 32'h0000_0000);
      send_instruction(CMD_ADD,  3'd6, 3'd6, 3'd6, 32'h0);
      send_instruction(CMD_HALT, 3'd0, 3'd0, 3'd0, 32'h0);

      // random segments, idle phase rotates with the item count
      while (item_count < ITEM_TARGET) begin
         case ((item_count / PHASE_ITEMS) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         seg = (fills_done == 0) ? 7 : $urandom_range(0, 9);
         case (seg)
            0, 1, 2, 3: begin
               // arithmetic and loads
               n = $urandom_range(4, 12);
               repeat (n)
                  send_instruction(command_type'($urandom_range(0, 3)), rand_reg(), rand_reg(),
                                   rand_reg(), pick_immediate());
            end
            4, 5: begin
               // push burst followed by a pop burst
               n = $urandom_range(1, 16);
               repeat (n)
                  send_instruction(CMD_PUSH, rand_reg(), rand_reg(), rand_reg(), $urandom());
               n = $urandom_range(1, 16);
               repeat (n)
                  send_instruction(CMD_POP, rand_reg(), rand_reg(), rand_reg(), $urandom());
            end
            6: begin
               // drain to empty and underflow
               while (stack_level > 0)
                  send_instruction(CMD_POP, rand_reg(), rand_reg(), rand_reg(), $urandom());
               repeat ($urandom_range(1, 2))
                  send_instruction(CMD_POP, rand_reg(), rand_reg(), rand_reg(), $urandom());
            end
            7: begin
               if (fills_done < 2) begin
                  fill_stack();
               end else begin
                  send_instruction(CMD_HALT, rand_reg(), rand_reg(), rand_reg(), $urandom());
               end
            end
            8: begin
               // noise over every command and field
               n = $urandom_range(1, 8);
               repeat (n)
                  send_instruction(command_type'($urandom_range(0, 7)), rand_reg(), rand_reg(),
                                   rand_reg(), $urandom());
            end
            default: begin
               // halt and unknown mixed with loads
               n = $urandom_range(2, 6);
               repeat (n)
                  send_instruction(command_type'($urandom_range(0, 1) ? CMD_HALT :
                                   ($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_LOAD)),
                                   rand_reg(), rand_reg(), rand_reg(), pick_immediate());
            end
         endcase
      end

      // wait for outstanding results, then a short quiet tail
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
sv/rsie_pkg.sv
sv/rsie_req_if.sv
sv/rsie_rsp_if.sv
sv/rsie_ram.sv
sv/rsie_front.sv
sv/rsie_queue.sv
sv/rsie_back.sv
sv/register_stack_instruction_executor.sv
dv/rsie_checker.sv
dv/testbench.sv
